### rtl/swsmm_pkg.sv
// ----------------------------------------------------------------------------
// swsmm_pkg
// Types and constants shared by the sliding window sum, minimum and mean block.
// ----------------------------------------------------------------------------
package swsmm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 38;
    localparam int MIN_W    = 33;
    localparam int CNT_W    = 7;

    // 65536.0 in Q16.16, one above the largest sample
    localparam logic [MIN_W-1:0] MIN_START = {1'b1, {SAMPLE_W{1'b0}}};

    // one quotient bit per step over the whole sum
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVICT,
        S_SCAN,
        S_OLD,
        S_OLDW,
        S_DONE
    } swsmm_state_t;

endpackage

### rtl/sliding_window_sum_min_mean.sv
// ----------------------------------------------------------------------------
// sliding_window_sum_min_mean
// Ring of window samples with running sum, minimum and truncated mean.
// ----------------------------------------------------------------------------
// One Q16.16 sample per transaction goes into a ring of window_size slots held
// in a single-port-write, registered-read memory; each transaction returns one
// result with the window sum, sum / fill count, minimum, the slot due to be
// overwritten next and the fill count. Items are handled one at a time. The
// mean comes from a restoring divider (38 steps, one quotient bit a cycle),
// which starts as soon as the sum is known. When the evicted sample was the
// minimum and the new one is larger, the minimum is rescanned from memory at
// one slot a cycle while the divider runs alongside. A new sample is taken
// once the result is in the output register, even if that result has not yet
// been collected. Slots are filled in order, so the fill count tells which
// slots hold data and no clearing pass is needed after reset or a window_size
// write.
// ----------------------------------------------------------------------------
module sliding_window_sum_min_mean
    import swsmm_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,

    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [SAMPLE_W-1:0] sample,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [SUM_W-1:0]    window_sum,
    output logic [SAMPLE_W-1:0] window_mean,
    output logic [SAMPLE_W-1:0] window_min,
    output logic [SAMPLE_W-1:0] oldest_value,
    output logic [CNT_W-1:0]    fill_count
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [CNT_W-1:0] slots_in_use(input logic [CNT_W-1:0] ws);
        logic [CNT_W-1:0] n;
        if (ws == '0)
            n = CNT_W'(1);
        else if (32'(ws) > DEPTH)
            n = CNT_W'(DEPTH);
        else
            n = ws;
        return n;
    endfunction

    // control state
    swsmm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]      ws_reg, ws_next;
    logic [CNT_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [MIN_W-1:0]      min_reg, min_next;
    logic                  was_full_reg, was_full_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  scan_pend_reg, scan_pend_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  result_valid_reg, result_valid_next;

    // payload
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [SUM_W-1:0]      div_q_reg, div_q_next;
    logic [CNT_W-1:0]      div_r_reg, div_r_next;
    logic [SAMPLE_W-1:0]   oldest_reg, oldest_next;
    logic [SUM_W-1:0]      out_sum_reg, out_sum_next;
    logic [SAMPLE_W-1:0]   out_mean_reg, out_mean_next;
    logic [SAMPLE_W-1:0]   out_min_reg, out_min_next;
    logic [SAMPLE_W-1:0]   out_oldest_reg, out_oldest_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;

    // sample store
    logic [SAMPLE_W-1:0]   mem [DEPTH];
    logic [SAMPLE_W-1:0]   rdata_reg;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;

    logic [CNT_W-1:0]      size;
    logic [CNT_W-1:0]      slot_inc;
    logic [CNT_W-1:0]      slot_wrap;
    logic [SAMPLE_W-1:0]   evicted;
    logic [SUM_W-1:0]      sum_new;
    logic [CNT_W:0]        div_shift;
    logic                  out_free;

    always_comb
    begin
        size      = slots_in_use(ws_reg);
        slot_inc  = slot_reg + CNT_W'(1);
        slot_wrap = (slot_inc >= size) ? '0 : slot_inc;
        evicted   = was_full_reg ? rdata_reg : '0;
        sum_new   = sum_reg - SUM_W'(evicted) + SUM_W'(sample_reg);
        out_free  = !result_valid_reg || !result_stall;
        div_shift = {div_r_reg, div_q_reg[SUM_W-1]};

        state_next        = state_reg;
        ws_next           = ws_reg;
        slot_next         = slot_reg;
        held_next         = held_reg;
        sum_next          = sum_reg;
        min_next          = min_reg;
        was_full_next     = was_full_reg;
        scan_idx_next     = scan_idx_reg;
        scan_pend_next    = scan_pend_reg;
        div_cnt_next      = div_cnt_reg;
        result_valid_next = result_valid_reg;
        sample_next       = sample_reg;
        div_q_next        = div_q_reg;
        div_r_next        = div_r_reg;
        oldest_next       = oldest_reg;
        out_sum_next      = out_sum_reg;
        out_mean_next     = out_mean_reg;
        out_min_next      = out_min_reg;
        out_oldest_next   = out_oldest_reg;
        out_count_next    = out_count_reg;
        mem_raddr         = ADDR_W'(slot_reg);
        mem_we            = 1'b0;

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        // restoring divider, one quotient bit a cycle
        if (div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            if (div_shift >= {1'b0, held_reg})
            begin
                div_r_next = CNT_W'(div_shift - {1'b0, held_reg});
                div_q_next = {div_q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                div_r_next = div_shift[CNT_W-1:0];
                div_q_next = {div_q_reg[SUM_W-2:0], 1'b0};
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next   = sample;
                    held_next     = (held_reg + CNT_W'(1) < size) ? held_reg + CNT_W'(1) : size;
                    slot_next     = slot_wrap;
                    was_full_next = (held_reg == size);
                    state_next    = S_RD;
                end
            end

            S_RD:
            begin
                mem_raddr  = ADDR_W'(slot_reg);
                state_next = S_EVICT;
            end

            S_EVICT:
            begin
                sum_next     = sum_new;
                mem_we       = 1'b1;
                div_q_next   = sum_new;
                div_r_next   = '0;
                div_cnt_next = DIV_CNT_W'(DIV_STEPS);
                if (MIN_W'(sample_reg) <= min_reg)
                begin
                    min_next   = MIN_W'(sample_reg);
                    state_next = S_OLD;
                end
                else if (MIN_W'(evicted) == min_reg)
                begin
                    min_next       = MIN_START;
                    scan_idx_next  = '0;
                    scan_pend_next = 1'b0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_OLD;
                end
            end

            S_SCAN:
            begin
                // read one slot a cycle, compare the data of the previous read
                mem_raddr = ADDR_W'(scan_idx_reg);
                if (scan_pend_reg && (MIN_W'(rdata_reg) < min_reg))
                    min_next = MIN_W'(rdata_reg);
                if (scan_idx_reg < held_reg)
                begin
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                    scan_pend_next = 1'b1;
                end
                else
                begin
                    scan_pend_next = 1'b0;
                    if (!scan_pend_reg)
                        state_next = S_OLD;
                end
            end

            S_OLD:
            begin
                mem_raddr  = ADDR_W'(slot_wrap);
                state_next = S_OLDW;
            end

            S_OLDW:
            begin
                // slots at or beyond the fill count were never written
                oldest_next = (slot_wrap < held_reg) ? rdata_reg : '0;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if ((div_cnt_reg == '0) && out_free)
                begin
                    out_sum_next      = (ws_reg == '0) ? '0 : sum_reg;
                    out_mean_next     = div_q_reg[SAMPLE_W-1:0];
                    out_min_next      = min_reg[SAMPLE_W-1:0];
                    out_oldest_next   = oldest_reg;
                    out_count_next    = held_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a window_size write restarts the window under the new size
        if (cfg_wr_en)
        begin
            ws_next   = cfg_wr_data;
            slot_next = slots_in_use(cfg_wr_data) - CNT_W'(1);
            held_next = '0;
            sum_next  = '0;
            min_next  = MIN_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ws_reg           <= CNT_W'(64);
            slot_reg         <= slots_in_use(CNT_W'(64)) - CNT_W'(1);
            held_reg         <= '0;
            sum_reg          <= '0;
            min_reg          <= MIN_START;
            was_full_reg     <= 1'b0;
            scan_idx_reg     <= '0;
            scan_pend_reg    <= 1'b0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ws_reg           <= ws_next;
            slot_reg         <= slot_next;
            held_reg         <= held_next;
            sum_reg          <= sum_next;
            min_reg          <= min_next;
            was_full_reg     <= was_full_next;
            scan_idx_reg     <= scan_idx_next;
            scan_pend_reg    <= scan_pend_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        oldest_reg     <= oldest_next;
        out_sum_reg    <= out_sum_next;
        out_mean_reg   <= out_mean_next;
        out_min_reg    <= out_min_next;
        out_oldest_reg <= out_oldest_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[ADDR_W'(slot_reg)] <= sample_reg;
        rdata_reg <= mem[mem_raddr];
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign window_sum   = out_sum_reg;
    assign window_mean  = out_mean_reg;
    assign window_min   = out_min_reg;
    assign oldest_value = out_oldest_reg;
    assign fill_count   = out_count_reg;

    // fill count never runs past the window
    a_held_capped: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= slots_in_use(ws_reg))
        else $error("fill count beyond window size");

    // a result is only shown once the mean has finished
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(div_cnt_reg) == '0))
        else $error("result shown before divider finished");

    // the minimum is either a real sample or exactly the start value
    a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg[MIN_W-1] |-> (min_reg[SAMPLE_W-1:0] == '0))
        else $error("running minimum above start value");

    // the write slot always lies inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < slots_in_use(ws_reg))
        else $error("write slot outside window");

endmodule

### test/tb_sliding_window_sum_min_mean.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_sum_min_mean
// Drives Q16.16 samples through the sliding window block over a range of
// window sizes and checks every result against a cycle-free model of the ring,
// with random gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_sliding_window_sum_min_mean;
    import swsmm_pkg::*;

    localparam int               DEPTH        = 64;
    localparam int               QUIET_LIMIT  = 2000;
    localparam int               DRAIN_CYCLES = 80;
    localparam int               IDLE_PCT     = 38;
    localparam logic [CNT_W-1:0] WIN_RESET    = 7'd64;

    typedef struct packed {
        logic [SUM_W-1:0]    win_sum;
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] oldest;
        logic [CNT_W-1:0]    count;
    } window_result_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data  = '0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample       = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [SUM_W-1:0]    window_sum;
    logic [SAMPLE_W-1:0] window_mean;
    logic [SAMPLE_W-1:0] window_min;
    logic [SAMPLE_W-1:0] oldest_value;
    logic [CNT_W-1:0]    fill_count;

    // model of the ring
    logic [CNT_W-1:0]    win_cfg;
    logic [SAMPLE_W-1:0] ring [DEPTH];
    int                  ring_slot;
    int                  ring_held;
    logic [SUM_W-1:0]    ring_sum;
    logic [MIN_W-1:0]    ring_min;

    logic [SAMPLE_W-1:0] sample_backlog [$];
    window_result_t      due_results [$];
    window_result_t      result_due;
    logic                steady        = 1'b0;
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;

    sliding_window_sum_min_mean #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_sum   (window_sum),
        .window_mean  (window_mean),
        .window_min   (window_min),
        .oldest_value (oldest_value),
        .fill_count   (fill_count)
    );

    always #6 clk = ~clk;

    function automatic int slots_for(input logic [CNT_W-1:0] w);
        if (w == '0)
            return 1;
        if (int'(w) > DEPTH)
            return DEPTH;
        return int'(w);
    endfunction

    function automatic void window_resize(input logic [CNT_W-1:0] w);
        win_cfg = w;
        foreach (ring[i])
            ring[i] = '0;
        ring_slot = slots_for(w) - 1;
        ring_held = 0;
        ring_sum  = '0;
        ring_min  = MIN_START;
    endfunction

    function automatic window_result_t window_advance(input logic [SAMPLE_W-1:0] s);
        window_result_t      r;
        int                  size;
        logic [SAMPLE_W-1:0] evicted;
        logic [SAMPLE_W-1:0] v;
        logic [MIN_W-1:0]    lowest;
        logic [SUM_W-1:0]    quotient;
        size      = slots_for(win_cfg);
        ring_held = (ring_held + 1 < size) ? ring_held + 1 : size;
        ring_slot = (ring_slot + 1) % size;
        evicted   = ring[ring_slot];
        ring_sum  = ring_sum - SUM_W'(evicted) + SUM_W'(s);
        if (MIN_W'(s) <= ring_min)
            ring_min = MIN_W'(s);
        else if (MIN_W'(evicted) == ring_min)
        begin
            // minimum evicted by a larger sample: rescan the filled slots
            lowest = MIN_START;
            for (int i = 0; i < ring_held; i++)
            begin
                v = (i == ring_slot) ? s : ring[i];
                if (MIN_W'(v) < lowest)
                    lowest = MIN_W'(v);
            end
            ring_min = lowest;
        end
        ring[ring_slot] = s;
        quotient  = ring_sum / SUM_W'(ring_held);
        r.win_sum = (win_cfg == '0) ? '0 : ring_sum;
        r.mean    = quotient[SAMPLE_W-1:0];
        r.minimum = ring_min[SAMPLE_W-1:0];
        r.oldest  = ring[(ring_slot + 1) % size];
        r.count   = CNT_W'(ring_held);
        return r;
    endfunction

    // biased towards small values and extremes so that ties and rescans are common
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return SAMPLE_W'($urandom_range(0, 15));
            7:          return SAMPLE_W'($urandom_range(0, 15) << 16);
            8:          return '0;
            default:    return '1;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (sample_backlog.size() != 0 || sample_valid || due_results.size() != 0);
    endtask

    task automatic write_window(input logic [CNT_W-1:0] w);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        window_resize(w);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_items(input int n);
        repeat (n)
            sample_backlog.push_back(pick_sample());
        wait_idle();
    endtask

    // sample side: a stalled transaction keeps its payload
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                due_results.push_back(window_advance(sample));
            if (!sample_valid || !sample_stall)
            begin
                if (sample_backlog.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    sample       <= sample_backlog.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("unexpected result, window_sum", window_sum, '0);
                end
                else
                begin
                    result_due = due_results.pop_front();
                    if (window_sum !== result_due.win_sum)
                        report_mismatch("window_sum", window_sum, result_due.win_sum);
                    if (window_mean !== result_due.mean)
                        report_mismatch("window_mean", window_mean, result_due.mean);
                    if (window_min !== result_due.minimum)
                        report_mismatch("window_min", window_min, result_due.minimum);
                    if (oldest_value !== result_due.oldest)
                        report_mismatch("oldest_value", oldest_value, result_due.oldest);
                    if (fill_count !== result_due.count)
                        report_mismatch("fill_count", fill_count, result_due.count);
                end
            end
            result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int               total;
        int               n;
        int               pick;
        logic [CNT_W-1:0] win;

        window_resize(WIN_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // zero minimum first, then extremes, reset window size
        sample_backlog = {32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0001_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        wait_idle();
        // single slot: each transaction evicts the minimum
        write_window(7'd1);
        sample_backlog = {32'd7, 32'd3, 32'd9, 32'hFFFF_FFFF};
        wait_idle();
        // one-slot mode with the sum reported as zero
        write_window(7'd0);
        sample_backlog = {32'd10, 32'hFFFF_FFFF, 32'd0, 32'd4};
        wait_idle();
        // oversized windows saturate
        write_window(7'd127);
        sample_backlog = {32'd1, 32'd2, 32'd3};
        wait_idle();
        write_window(7'd65);
        sample_backlog = {32'hFFFF_FFFF, 32'hFFFF_FFFE};
        wait_idle();
        write_window(7'd2);
        sample_backlog = {32'd3, 32'd1, 32'd4, 32'd1, 32'd5};
        wait_idle();

        // long run on the full window with no gaps or stalls
        steady <= 1'b1;
        write_window(WIN_RESET);
        run_items(90);
        steady <= 1'b0;
        total = 90;

        while (total < 450)
        begin
            pick = $urandom_range(0, 7);
            if (pick < 4)
                win = CNT_W'($urandom_range(0, 8));
            else if (pick < 6)
                win = CNT_W'($urandom_range(9, 64));
            else
                win = CNT_W'($urandom_range(0, 127));
            // now and then carry the ring over into the next phase
            if ($urandom_range(0, 3) != 0)
            begin
                write_window(win);
                n = slots_for(win) + $urandom_range(4, 30);
            end
            else
            begin
                n = $urandom_range(10, 40);
            end
            run_items(n);
            total += n;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
